// ===== rtl/core/rolac_pkg.sv =====
package rolac_pkg;

  typedef enum logic [2:0] {
    REG_RPM_WINDOW        = 3'd0,
    REG_SPEED_WINDOW      = 3'd1,
    REG_GEAR_AND_THROTTLE = 3'd2,
    REG_WOT_MEMORY_MS     = 3'd3,
    REG_MAX_ACTIVE_MS     = 3'd4,
    REG_COOLANT_LIMIT     = 3'd5,
    REG_BOOST_LIMIT       = 3'd6,
    REG_CONTROL_WORD      = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [31:0] RPM_WINDOW_RST        = 32'd458755000;
  localparam logic [31:0] SPEED_WINDOW_RST      = 32'd78643500;
  localparam logic [31:0] GEAR_AND_THROTTLE_RST = 32'd503972866;
  localparam logic [31:0] WOT_MEMORY_MS_RST     = 32'd2000;
  localparam logic [31:0] MAX_ACTIVE_MS_RST     = 32'd3000;
  localparam logic [15:0] COOLANT_LIMIT_RST     = 16'd1050;
  localparam logic [15:0] BOOST_LIMIT_RST       = 16'd150;
  localparam logic [23:0] CONTROL_WORD_RST      = 24'd1640960;

  localparam logic [7:0] WOT_THROTTLE = 8'd95;
  localparam logic [7:0] CUT_ALL      = 8'd100;
  localparam logic [7:0] CUT_QUARTER  = 8'd25;
  localparam logic [7:0] CUT_HALF     = 8'd50;
  localparam logic [1:0] PHASE_LAST   = 2'd3;

  typedef struct packed {
    logic [31:0]        rpm_window;
    logic [31:0]        speed_window;
    logic [31:0]        gear_and_throttle;
    logic [31:0]        wot_memory_ms;
    logic [31:0]        max_active_ms;
    logic signed [15:0] coolant_limit;
    logic [15:0]        boost_limit;
    logic [23:0]        control_word;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        engine_rpm;
    logic [7:0]         throttle_pct;
    logic [15:0]        road_speed;
    logic [7:0]         gear_number;
    logic [15:0]        boost_level;
    logic signed [15:0] water_temp;
    logic [31:0]        now_ms;
  } sample_t;

  typedef struct packed {
    logic               is_active;
    logic               conditions_ok;
    logic               wot_remembered;
    logic signed [7:0]  timing_adjust;
    logic               cut_fuel;
    logic [31:0]        active_duration_ms;
    logic [31:0]        activation_total;
    logic [31:0]        active_time_total;
  } result_t;

endpackage

// ===== rtl/core/rolac_cfg.sv =====
module rolac_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rolac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rolac_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rolac_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rpm_window        <= rolac_pkg::RPM_WINDOW_RST;
      cfg.speed_window      <= rolac_pkg::SPEED_WINDOW_RST;
      cfg.gear_and_throttle <= rolac_pkg::GEAR_AND_THROTTLE_RST;
      cfg.wot_memory_ms     <= rolac_pkg::WOT_MEMORY_MS_RST;
      cfg.max_active_ms     <= rolac_pkg::MAX_ACTIVE_MS_RST;
      cfg.coolant_limit     <= rolac_pkg::COOLANT_LIMIT_RST;
      cfg.boost_limit       <= rolac_pkg::BOOST_LIMIT_RST;
      cfg.control_word      <= rolac_pkg::CONTROL_WORD_RST;
    end else if (cfg_write) begin
      unique case (rolac_pkg::cfg_reg_t'(cfg_index))
        rolac_pkg::REG_RPM_WINDOW:        cfg.rpm_window        <= cfg_data;
        rolac_pkg::REG_SPEED_WINDOW:      cfg.speed_window      <= cfg_data;
        rolac_pkg::REG_GEAR_AND_THROTTLE: cfg.gear_and_throttle <= cfg_data;
        rolac_pkg::REG_WOT_MEMORY_MS:     cfg.wot_memory_ms     <= cfg_data;
        rolac_pkg::REG_MAX_ACTIVE_MS:     cfg.max_active_ms     <= cfg_data;
        rolac_pkg::REG_COOLANT_LIMIT:     cfg.coolant_limit     <= $signed(cfg_data[15:0]);
        rolac_pkg::REG_BOOST_LIMIT:       cfg.boost_limit       <= cfg_data[15:0];
        rolac_pkg::REG_CONTROL_WORD:      cfg.control_word      <= cfg_data[23:0];
      endcase
    end
  end

endmodule

// ===== rtl/core/rolac_cond.sv =====
module rolac_cond (
  input  rolac_pkg::cfg_t    cfg,
  input  rolac_pkg::sample_t smp,
  input  logic               wot,
  input  logic               active,
  output logic               cond_ok
);

  logic [15:0] rpm_min, rpm_max, spd_min, spd_max;
  logic [7:0]  gear_min, gear_max, thr_limit;
  logic        rpm_ok, spd_ok, gear_ok, thr_ok, temp_ok, boost_ok;

  assign rpm_min  = cfg.rpm_window[15:0];
  assign rpm_max  = cfg.rpm_window[31:16];
  assign spd_min  = cfg.speed_window[15:0];
  assign spd_max  = cfg.speed_window[31:16];
  assign gear_min = cfg.gear_and_throttle[7:0];
  assign gear_max = cfg.gear_and_throttle[15:8];
  // hysteresis: the lift threshold switches once active
  assign thr_limit = active ? cfg.gear_and_throttle[31:24] : cfg.gear_and_throttle[23:16];

  assign rpm_ok   = (smp.engine_rpm >= rpm_min) && (smp.engine_rpm <= rpm_max);
  // a zero upper speed means no upper bound
  assign spd_ok   = (smp.road_speed >= spd_min) &&
                    ((spd_max == 16'd0) || (smp.road_speed <= spd_max));
  assign gear_ok  = (smp.gear_number >= gear_min) && (smp.gear_number <= gear_max);
  assign thr_ok   = smp.throttle_pct <= thr_limit;
  assign temp_ok  = smp.water_temp <= cfg.coolant_limit;
  assign boost_ok = smp.boost_level <= cfg.boost_limit;

  assign cond_ok = wot && rpm_ok && spd_ok && gear_ok && thr_ok && temp_ok && boost_ok;

endmodule

// ===== rtl/core/rolac_core.sv =====
module rolac_core (
  input  logic                clk,
  input  logic                rst,
  input  rolac_pkg::cfg_t     cfg,
  input  rolac_pkg::sample_t  smp,
  input  logic                fire,
  output rolac_pkg::result_t  res
);

  logic        active, cond_flag, wot;
  logic [31:0] last_wot_stamp, activation_stamp, duration;
  logic [31:0] activation_count, active_time_acc;
  logic [1:0]  cut_phase;

  logic        active_next, cond_flag_next, wot_next;
  logic [31:0] last_wot_stamp_next, activation_stamp_next, duration_next;
  logic [31:0] activation_count_next, active_time_acc_next;
  logic [1:0]  cut_phase_next;

  logic        enable, cond_ok, acc_add, cut;
  logic [31:0] wot_age, active_age;
  logic [7:0]  retard, ratio;

  assign enable     = cfg.control_word[0];
  assign retard     = cfg.control_word[15:8];
  assign ratio      = cfg.control_word[23:16];
  assign wot_age    = smp.now_ms - last_wot_stamp;
  assign active_age = smp.now_ms - activation_stamp;

  always_comb begin
    wot_next            = wot;
    last_wot_stamp_next = last_wot_stamp;
    if (smp.throttle_pct >= rolac_pkg::WOT_THROTTLE) begin
      wot_next            = 1'b1;
      last_wot_stamp_next = smp.now_ms;
    end else if (wot_age > cfg.wot_memory_ms) begin
      wot_next = 1'b0;
    end
  end

  rolac_cond u_cond (
    .cfg     (cfg),
    .smp     (smp),
    .wot     (wot_next),
    .active  (active),
    .cond_ok (cond_ok)
  );

  always_comb begin
    active_next           = active;
    cond_flag_next        = cond_flag;
    activation_stamp_next = activation_stamp;
    duration_next         = duration;
    activation_count_next = activation_count;
    cut_phase_next        = cut_phase;
    acc_add               = 1'b0;
    if (!enable) begin
      if (active) begin
        acc_add               = 1'b1;
        active_next           = 1'b0;
        cond_flag_next        = 1'b0;
        activation_stamp_next = '0;
        duration_next         = '0;
      end
    end else begin
      cond_flag_next = cond_ok;
      cut_phase_next = cut_phase + 2'd1;
      if (cond_ok && !active) begin
        activation_count_next = activation_count + 32'd1;
        duration_next         = '0;
        if (cfg.max_active_ms == 32'd0) begin
          // counted, then forced off in the same request
          cond_flag_next        = 1'b0;
          activation_stamp_next = '0;
        end else begin
          active_next           = 1'b1;
          activation_stamp_next = smp.now_ms;
        end
      end else if (!cond_ok && active) begin
        acc_add               = 1'b1;
        active_next           = 1'b0;
        activation_stamp_next = '0;
        duration_next         = '0;
      end else if (cond_ok && active) begin
        if (active_age >= cfg.max_active_ms) begin
          acc_add               = 1'b1;
          active_next           = 1'b0;
          cond_flag_next        = 1'b0;
          activation_stamp_next = '0;
          duration_next         = '0;
        end else begin
          duration_next = active_age;
        end
      end
    end
    active_time_acc_next = acc_add ? active_time_acc + active_age : active_time_acc;
  end

  // cut pattern on the advanced phase
  always_comb begin
    cut = 1'b0;
    if (active_next && (ratio != 8'd0)) begin
      if (ratio >= rolac_pkg::CUT_ALL) begin
        cut = 1'b1;
      end else if (ratio <= rolac_pkg::CUT_QUARTER) begin
        cut = (cut_phase_next == 2'd0);
      end else if (ratio <= rolac_pkg::CUT_HALF) begin
        cut = ~cut_phase_next[0];
      end else begin
        cut = (cut_phase_next != rolac_pkg::PHASE_LAST);
      end
    end
  end

  always_comb begin
    res.is_active          = active_next;
    res.conditions_ok      = cond_flag_next;
    res.wot_remembered     = enable ? wot_next : wot;
    res.timing_adjust      = active_next ? $signed(8'd0 - retard) : 8'sd0;
    res.cut_fuel           = cut;
    res.active_duration_ms = duration_next;
    res.activation_total   = activation_count_next;
    res.active_time_total  = active_time_acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      cond_flag        <= 1'b0;
      wot              <= 1'b0;
      last_wot_stamp   <= '0;
      activation_stamp <= '0;
      duration         <= '0;
      activation_count <= '0;
      active_time_acc  <= '0;
      cut_phase        <= '0;
    end else if (fire) begin
      active           <= active_next;
      cond_flag        <= cond_flag_next;
      activation_stamp <= activation_stamp_next;
      duration         <= duration_next;
      activation_count <= activation_count_next;
      active_time_acc  <= active_time_acc_next;
      cut_phase        <= cut_phase_next;
      if (enable) begin
        wot            <= wot_next;
        last_wot_stamp <= last_wot_stamp_next;
      end
    end
  end

  ap_phase_hold: assert property (@(posedge clk) disable iff (rst)
    fire && !enable |=> $stable(cut_phase))
    else $error("cut phase moved on a disabled request");

  ap_inactive_clear: assert property (@(posedge clk) disable iff (rst)
    !active |-> (duration == 32'd0) && (activation_stamp == 32'd0 || !active))
    else $error("duration held while inactive");

  ap_active_cond: assert property (@(posedge clk) disable iff (rst)
    active |-> cond_flag && wot)
    else $error("active without conditions or full-throttle memory");

endmodule

// ===== rtl/core/rolling_antilag_controller.sv =====
// Channel  Direction  Handshake            Payload
// in       into block in_valid / in_stall   engine_rpm throttle_pct road_speed gear_number
//                                            boost_level water_temp now_ms
// out      from block out_valid / out_stall is_active conditions_ok wot_remembered
//                                            timing_adjust cut_fuel active_duration_ms
//                                            activation_total active_time_total
// cfg      into block cfg_write             cfg_index cfg_data
//
// One request per cycle sustained while out does not stall; a taken request passes the input
// register, then the result register. All decision logic sits between those registers.
// Synchronous reset loads the register defaults and clears all controller state.
// A stall on out holds the result register; in stalls only while the input register is full
// and the result register cannot move.
module rolling_antilag_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rolac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rolac_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       engine_rpm,
  input  logic [7:0]                        throttle_pct,
  input  logic [15:0]                       road_speed,
  input  logic [7:0]                        gear_number,
  input  logic [15:0]                       boost_level,
  input  logic signed [15:0]                water_temp,
  input  logic [31:0]                       now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              is_active,
  output logic                              conditions_ok,
  output logic                              wot_remembered,
  output logic signed [7:0]                 timing_adjust,
  output logic                              cut_fuel,
  output logic [31:0]                       active_duration_ms,
  output logic [31:0]                       activation_total,
  output logic [31:0]                       active_time_total
);

  rolac_pkg::cfg_t    cfg;
  rolac_pkg::sample_t smp;
  rolac_pkg::result_t res, res_q;
  logic               smp_valid, advance, fire;

  rolac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = !out_valid || !out_stall;
  assign fire     = smp_valid && advance;
  assign in_stall = smp_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!in_stall) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      smp.engine_rpm   <= engine_rpm;
      smp.throttle_pct <= throttle_pct;
      smp.road_speed   <= road_speed;
      smp.gear_number  <= gear_number;
      smp.boost_level  <= boost_level;
      smp.water_temp   <= water_temp;
      smp.now_ms       <= now_ms;
    end
  end

  rolac_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .smp  (smp),
    .fire (fire),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign is_active          = res_q.is_active;
  assign conditions_ok      = res_q.conditions_ok;
  assign wot_remembered     = res_q.wot_remembered;
  assign timing_adjust      = res_q.timing_adjust;
  assign cut_fuel           = res_q.cut_fuel;
  assign active_duration_ms = res_q.active_duration_ms;
  assign activation_total   = res_q.activation_total;
  assign active_time_total  = res_q.active_time_total;

  ap_idle_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_active |->
      (active_duration_ms == 32'd0) && (timing_adjust == 8'sd0) && !cut_fuel)
    else $error("inactive result carries retard, cut or duration");

  ap_active_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_active |-> conditions_ok && wot_remembered)
    else $error("active result without conditions");

  ap_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_q))
    else $error("result lost under stall");

endmodule

// ===== tb/sv/tb_rolling_antilag_controller.sv =====
module tb_rolling_antilag_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTING_ITEMS  = 80;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [rolac_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rolac_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [15:0]                      engine_rpm = '0;
  logic [7:0]                       throttle_pct = '0;
  logic [15:0]                      road_speed = '0;
  logic [7:0]                       gear_number = '0;
  logic [15:0]                      boost_level = '0;
  logic signed [15:0]               water_temp = '0;
  logic [31:0]                      now_ms = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic                             is_active;
  logic                             conditions_ok;
  logic                             wot_remembered;
  logic signed [7:0]                timing_adjust;
  logic                             cut_fuel;
  logic [31:0]                      active_duration_ms;
  logic [31:0]                      activation_total;
  logic [31:0]                      active_time_total;

  rolling_antilag_controller u_top (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .engine_rpm         (engine_rpm),
    .throttle_pct       (throttle_pct),
    .road_speed         (road_speed),
    .gear_number        (gear_number),
    .boost_level        (boost_level),
    .water_temp         (water_temp),
    .now_ms             (now_ms),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .is_active          (is_active),
    .conditions_ok      (conditions_ok),
    .wot_remembered     (wot_remembered),
    .timing_adjust      (timing_adjust),
    .cut_fuel           (cut_fuel),
    .active_duration_ms (active_duration_ms),
    .activation_total   (activation_total),
    .active_time_total  (active_time_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Controller copy: registers and state as the block should hold them
  rolac_pkg::cfg_t    cur_cfg;
  logic        eng_active, cond_met, wot_held;
  logic [31:0] wot_at, active_since, active_ms, activations, active_ms_total;
  logic [1:0]  cut_step;

  rolac_pkg::result_t due_results[$];
  rolac_pkg::result_t seen_result;
  rolac_pkg::result_t want_result;
  logic [31:0] sample_clock;
  int unsigned stamp_step_max = 100;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_loaded = 0;
  int unsigned forced_offs = 0;
  int unsigned backpressure_cycles = 0;

  function automatic rolac_pkg::cfg_t default_setting();
    rolac_pkg::cfg_t c;
    c.rpm_window        = rolac_pkg::RPM_WINDOW_RST;
    c.speed_window      = rolac_pkg::SPEED_WINDOW_RST;
    c.gear_and_throttle = rolac_pkg::GEAR_AND_THROTTLE_RST;
    c.wot_memory_ms     = rolac_pkg::WOT_MEMORY_MS_RST;
    c.max_active_ms     = rolac_pkg::MAX_ACTIVE_MS_RST;
    c.coolant_limit     = rolac_pkg::COOLANT_LIMIT_RST;
    c.boost_limit       = rolac_pkg::BOOST_LIMIT_RST;
    c.control_word      = rolac_pkg::CONTROL_WORD_RST;
    return c;
  endfunction

  function automatic void close_activation(logic [31:0] stamp_now);
    if (eng_active) active_ms_total += stamp_now - active_since;
    eng_active   = 1'b0;
    active_since = '0;
    active_ms    = '0;
    cond_met     = 1'b0;
  endfunction

  function automatic rolac_pkg::result_t predict_antilag(rolac_pkg::sample_t s);
    rolac_pkg::result_t r;
    logic [7:0] retard;
    logic [7:0] ratio;
    logic [7:0] thr_lim;
    logic       cut;
    retard = cur_cfg.control_word[15:8];
    ratio  = cur_cfg.control_word[23:16];
    cut    = 1'b0;
    if (!cur_cfg.control_word[0]) begin
      // disabled: drop any activation, leave the rest untouched
      if (eng_active) close_activation(s.now_ms);
    end else begin
      if (s.throttle_pct >= rolac_pkg::WOT_THROTTLE) begin
        wot_at   = s.now_ms;
        wot_held = 1'b1;
      end else if (s.now_ms - wot_at > cur_cfg.wot_memory_ms) begin
        wot_held = 1'b0;
      end
      // hysteresis: the lift threshold depends on whether already active
      thr_lim = eng_active ? cur_cfg.gear_and_throttle[31:24] : cur_cfg.gear_and_throttle[23:16];
      cond_met = wot_held
        && s.engine_rpm >= cur_cfg.rpm_window[15:0]
        && s.engine_rpm <= cur_cfg.rpm_window[31:16]
        && s.road_speed >= cur_cfg.speed_window[15:0]
        && (cur_cfg.speed_window[31:16] == 16'd0 || s.road_speed <= cur_cfg.speed_window[31:16])
        && s.gear_number >= cur_cfg.gear_and_throttle[7:0]
        && s.gear_number <= cur_cfg.gear_and_throttle[15:8]
        && s.throttle_pct <= thr_lim
        && $signed(s.water_temp) <= $signed(cur_cfg.coolant_limit)
        && s.boost_level <= cur_cfg.boost_limit;
      if (cond_met && !eng_active) begin
        eng_active   = 1'b1;
        active_since = s.now_ms;
        activations  = activations + 1;
      end else if (!cond_met && eng_active) begin
        close_activation(s.now_ms);
      end
      if (eng_active) begin
        active_ms = s.now_ms - active_since;
        if (active_ms >= cur_cfg.max_active_ms) begin
          close_activation(s.now_ms);
          forced_offs++;
        end
      end
      cut_step = cut_step + 2'd1;
    end
    if (eng_active && ratio != 8'd0) begin
      if (ratio >= rolac_pkg::CUT_ALL) cut = 1'b1;
      else if (ratio <= rolac_pkg::CUT_QUARTER) cut = (cut_step == 2'd0);
      else if (ratio <= rolac_pkg::CUT_HALF) cut = !cut_step[0];
      else cut = (cut_step != rolac_pkg::PHASE_LAST);
    end
    r.is_active          = eng_active;
    r.conditions_ok      = cond_met;
    r.wot_remembered     = wot_held;
    r.timing_adjust      = eng_active ? 8'd0 - retard : 8'd0;
    r.cut_fuel           = cut;
    r.active_duration_ms = active_ms;
    r.activation_total   = activations;
    r.active_time_total  = active_ms_total;
    return r;
  endfunction

  function automatic string fmt_result(rolac_pkg::result_t r);
    return $sformatf("act=%0b ok=%0b wot=%0b adj=%0d cut=%0b dur=%0d cnt=%0d tot=%0d",
                     r.is_active, r.conditions_ok, r.wot_remembered, r.timing_adjust,
                     r.cut_fuel, r.active_duration_ms, r.activation_total,
                     r.active_time_total);
  endfunction

  // Random value in [lo, hi], with the bounds themselves favoured; any value if lo > hi
  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    if (lo > hi) return $urandom;
    case ($urandom_range(4))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [31:0] next_stamp();
    if ($urandom_range(49) == 0) sample_clock = $urandom;
    else sample_clock = sample_clock + $urandom_range(stamp_step_max);
    return sample_clock;
  endfunction

  function automatic rolac_pkg::sample_t sample_of(int unsigned rpm, int unsigned thr,
                                                   int unsigned spd, int unsigned gear,
                                                   int unsigned boost, int cool,
                                                   logic [31:0] stamp);
    rolac_pkg::sample_t s;
    s.engine_rpm   = 16'(rpm);
    s.throttle_pct = 8'(thr);
    s.road_speed   = 16'(spd);
    s.gear_number  = 8'(gear);
    s.boost_level  = 16'(boost);
    s.water_temp   = 16'(cool);
    s.now_ms       = stamp;
    return s;
  endfunction

  function automatic rolac_pkg::sample_t in_window_sample();
    rolac_pkg::sample_t s;
    int          lim;
    int          span;
    int unsigned spd_hi;
    spd_hi = (cur_cfg.speed_window[31:16] == 16'd0) ? 16'hFFFF : cur_cfg.speed_window[31:16];
    s.engine_rpm  = 16'(pick(cur_cfg.rpm_window[15:0], cur_cfg.rpm_window[31:16]));
    s.road_speed  = 16'(pick(cur_cfg.speed_window[15:0], spd_hi));
    s.gear_number = 8'(pick(cur_cfg.gear_and_throttle[7:0], cur_cfg.gear_and_throttle[15:8]));
    if ($urandom_range(1) == 0) s.throttle_pct = 8'(pick(0, cur_cfg.gear_and_throttle[23:16]));
    else s.throttle_pct = 8'(pick(0, cur_cfg.gear_and_throttle[31:24]));
    s.boost_level = 16'(pick(0, cur_cfg.boost_limit));
    lim  = $signed(cur_cfg.coolant_limit);
    span = lim + 32768;
    if (span > 600) span = 600;
    s.water_temp = 16'(lim - int'(pick(0, span)));
    s.now_ms     = next_stamp();
    return s;
  endfunction

  function automatic rolac_pkg::sample_t noise_sample();
    rolac_pkg::sample_t s;
    s.engine_rpm   = 16'($urandom);
    s.throttle_pct = 8'($urandom);
    s.road_speed   = 16'($urandom);
    s.gear_number  = 8'($urandom);
    s.boost_level  = 16'($urandom);
    s.water_temp   = 16'($urandom);
    s.now_ms       = ($urandom_range(1) == 0) ? next_stamp() : 32'($urandom);
    return s;
  endfunction

  function automatic rolac_pkg::cfg_t random_setting();
    rolac_pkg::cfg_t c;
    c.rpm_window[15:0]  = 16'($urandom_range(4000));
    c.rpm_window[31:16] = c.rpm_window[15:0] + 16'($urandom_range(8000));
    if ($urandom_range(9) == 0) c.rpm_window = $urandom;
    c.speed_window[15:0]  = 16'($urandom_range(500));
    c.speed_window[31:16] = ($urandom_range(3) == 0) ? 16'd0
                            : c.speed_window[15:0] + 16'($urandom_range(2000));
    c.gear_and_throttle[7:0]   = 8'($urandom_range(3));
    c.gear_and_throttle[15:8]  = c.gear_and_throttle[7:0] + 8'($urandom_range(4));
    c.gear_and_throttle[23:16] = 8'($urandom_range(60));
    c.gear_and_throttle[31:24] = c.gear_and_throttle[23:16] + 8'($urandom_range(40));
    if ($urandom_range(9) == 0) c.gear_and_throttle = $urandom;
    c.wot_memory_ms = $urandom_range(3000, 50);
    c.max_active_ms = $urandom_range(5000);
    c.coolant_limit = 16'($urandom_range(1400)) - 16'd200;
    c.boost_limit   = 16'($urandom_range(400));
    c.control_word[0]    = ($urandom_range(9) != 0);
    c.control_word[7:1]  = 7'($urandom);
    c.control_word[15:8] = 8'($urandom);
    case ($urandom_range(5))
      0: c.control_word[23:16] = 8'd0;
      1: c.control_word[23:16] = 8'($urandom_range(25, 1));
      2: c.control_word[23:16] = 8'($urandom_range(50, 26));
      3: c.control_word[23:16] = 8'($urandom_range(99, 51));
      4: c.control_word[23:16] = 8'($urandom_range(255, 100));
      default: c.control_word[23:16] = 8'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_sample(rolac_pkg::sample_t s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    engine_rpm   <= s.engine_rpm;
    throttle_pct <= s.throttle_pct;
    road_speed   <= s.road_speed;
    gear_number  <= s.gear_number;
    boost_level  <= s.boost_level;
    water_temp   <= s.water_temp;
    now_ms       <= s.now_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_results.push_back(predict_antilag(s));
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    // result register may still be settling after the last one left
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(rolac_pkg::cfg_t c);
    rolac_pkg::cfg_reg_t idx;
    logic [31:0]         word;
    drain_results();
    for (int i = 0; i < 8; i++) begin
      idx = rolac_pkg::cfg_reg_t'(i);
      case (idx)
        rolac_pkg::REG_RPM_WINDOW:        word = c.rpm_window;
        rolac_pkg::REG_SPEED_WINDOW:      word = c.speed_window;
        rolac_pkg::REG_GEAR_AND_THROTTLE: word = c.gear_and_throttle;
        rolac_pkg::REG_WOT_MEMORY_MS:     word = c.wot_memory_ms;
        rolac_pkg::REG_MAX_ACTIVE_MS:     word = c.max_active_ms;
        // junk in the unused upper bits must be dropped
        rolac_pkg::REG_COOLANT_LIMIT:     word = {16'($urandom), c.coolant_limit};
        rolac_pkg::REG_BOOST_LIMIT:       word = {16'($urandom), c.boost_limit};
        rolac_pkg::REG_CONTROL_WORD:      word = {8'($urandom), c.control_word};
        default:                          word = '0;
      endcase
      cfg_write <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= word;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_cfg = c;
    settings_loaded++;
  endtask

  task automatic run_launch();
    rolac_pkg::sample_t s;
    int                 n;
    s = in_window_sample();
    s.throttle_pct = 8'($urandom_range(255, 95));
    send_sample(s);
    n = $urandom_range(30, 1);
    repeat (n) begin
      s = in_window_sample();
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(5))
          0: s.engine_rpm   = 16'($urandom);
          1: s.road_speed   = 16'($urandom);
          2: s.gear_number  = 8'($urandom);
          3: s.throttle_pct = 8'($urandom);
          4: s.boost_level  = 16'($urandom);
          default: s.water_temp = 16'($urandom);
        endcase
      end
      send_sample(s);
    end
  endtask

  // Reset register values leave the controller disabled
  task automatic test_reset_state();
    send_sample(sample_of(5000, 100, 600, 3, 100, 900, 32'd1000));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'd1100));
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 32'd0));
  endtask

  task automatic test_launch_basics();
    rolac_pkg::cfg_t c;
    c = default_setting();
    c.control_word[0] = 1'b1;
    load_setting(c);
    send_sample(sample_of(5000, 100, 600, 3, 100, 900, 32'd1000));
    send_sample(sample_of(5000, 5, 600, 3, 100, 900, 32'd1100));
    send_sample(sample_of(5000, 20, 600, 3, 100, 900, 32'd1200));
    send_sample(sample_of(5000, 31, 600, 3, 100, 900, 32'd1300));
    send_sample(sample_of(3000, 10, 300, 2, 150, 1050, 32'd1500));
    send_sample(sample_of(7000, 0, 1200, 4, 0, -32768, 32'd1600));
    send_sample(sample_of(7001, 0, 1200, 4, 0, 0, 32'd1650));
    send_sample(sample_of(65535, 255, 65535, 255, 65535, 32767, 32'd1700));
    // timestamps across the 32-bit wrap
    send_sample(sample_of(5000, 100, 600, 3, 100, 900, 32'hFFFF_FF00));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'hFFFF_FF80));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h0000_0100));
  endtask

  task automatic test_disable();
    rolac_pkg::cfg_t c;
    send_sample(sample_of(5000, 100, 600, 3, 100, 900, 32'h1000));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h1064));
    c = cur_cfg;
    c.control_word[0] = 1'b0;
    load_setting(c);
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h10C8));
    c.control_word[0] = 1'b1;
    load_setting(c);
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h112C));
  endtask

  task automatic test_forced_off();
    rolac_pkg::cfg_t c;
    c = default_setting();
    c.wot_memory_ms = 32'd5000;
    c.max_active_ms = 32'd500;
    c.control_word  = {8'd100, 8'd200, 8'h01};
    load_setting(c);
    send_sample(sample_of(5000, 100, 600, 3, 100, 900, 32'h2000));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h2010));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h2010 + 32'd499));
    send_sample(sample_of(5000, 0, 600, 3, 100, 900, 32'h2010 + 32'd500));
    // zero limits: an activation begins and ends in the same sample
    c = '0;
    c.control_word[0] = 1'b1;
    load_setting(c);
    send_sample(sample_of(0, 100, 0, 0, 0, 0, 32'h3000));
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 32'h3000));
    c = '1;
    load_setting(c);
    send_sample(sample_of(65535, 255, 65535, 255, 65535, -1, 32'h4000));
    send_sample(sample_of(65535, 255, 65535, 255, 65535, -1, 32'h43E8));
    send_sample(sample_of(65535, 255, 65535, 255, 65535, 0, 32'h4400));
  endtask

  task automatic test_random_launches();
    int unsigned idle_mode[4]  = '{0, 49, 0, 19};
    int unsigned stall_mode[4] = '{0, 0, 49, 19};
    int unsigned target;
    sample_clock = 32'hFFFF_0000;
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = idle_mode[m];
      stall_pct     = stall_mode[m];
      repeat (5) begin
        load_setting(random_setting());
        stamp_step_max = $urandom_range(400, 1);
        target = samples_sent + SETTING_ITEMS;
        while (samples_sent < target) begin
          if ($urandom_range(9) < 8) run_launch();
          else send_sample(noise_sample());
        end
      end
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming
  task automatic test_backpressure();
    rolac_pkg::cfg_t c;
    send_idle_pct = 0;
    stall_pct     = 0;
    c = random_setting();
    c.control_word[0] = 1'b1;
    load_setting(c);
    hold_cycles = 400;
    repeat (4) run_launch();
    stall_pct = 30;
    repeat (2) run_launch();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_result = {is_active, conditions_ok, wot_remembered, timing_adjust, cut_fuel,
                     active_duration_ms, activation_total, active_time_total};
      results_checked++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: %s", fmt_result(seen_result));
      end else begin
        want_result = due_results.pop_front();
        if (seen_result !== want_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d\n  exp %s\n  got %s", results_checked,
                     fmt_result(want_result), fmt_result(seen_result));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_stall) backpressure_cycles++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cur_cfg         = default_setting();
    eng_active      = 1'b0;
    cond_met        = 1'b0;
    wot_held        = 1'b0;
    wot_at          = '0;
    active_since    = '0;
    active_ms       = '0;
    activations     = '0;
    active_ms_total = '0;
    cut_step        = '0;
    sample_clock    = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_launch_basics();
    test_disable();
    test_forced_off();
    test_random_launches();
    test_backpressure();
    drain_results();
    $display("%0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_loaded, results_checked);
    $display("%0d activations, %0d forced cut-offs, %0d cycles of input back-pressure",
             activations, forced_offs, backpressure_cycles);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures, %0d results never arrived", mismatches, due_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
